// File: hdl/lrrd_pkg.sv
// ----------------------------------------------------------------------------
// lrrd_pkg
// Shared types and constants for the Lehmer range draw unit.
// ----------------------------------------------------------------------------
package lrrd_pkg;

  localparam int unsigned WORD_W = 32;

  // generator constants
  localparam logic [15:0]     LEHMER_MULT = 16'd48271;
  localparam logic [31:0]     MOD_MASK    = 32'h7fff_ffff;
  localparam logic [31:0]     SPAN_TOP    = 32'h8000_0000;
  localparam logic [31:0]     SEED_RESET  = 32'd10;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_MUL,
    S_FOLD,
    S_NEXT,
    S_TEST,
    S_DIV2,
    S_OUT
  } lrrd_state_t;

  // serial divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hdl/lrrd_if.sv
// ----------------------------------------------------------------------------
// lrrd_req_if / lrrd_res_if
// Valid/ready channels for draw requests and draw results.
// ----------------------------------------------------------------------------
interface lrrd_req_if;
  import lrrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] min_value;
  logic [WORD_W-1:0] max_value;

  modport source (output valid, output min_value, output max_value, input ready);
  modport sink   (input valid, input min_value, input max_value, output ready);
endinterface

interface lrrd_res_if;
  import lrrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              range_error;

  modport source (output valid, output value, output range_error, input ready);
  modport sink   (input valid, input value, input range_error, output ready);
endinterface

// File: hdl/lrrd_div.sv
// ----------------------------------------------------------------------------
// lrrd_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrrd_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [31:0]         divisor,
  output logic [31:0]         quotient,
  output logic [31:0]         remainder,
  output lrrd_pkg::div_status_t status
);
  import lrrd_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic [32:0] diff;

  // one trial subtraction per cycle
  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: hdl/lehmer_rng_range_draw_unit.sv
// ----------------------------------------------------------------------------
// lehmer_rng_range_draw_unit
// Uniform draw from an inclusive range on a MINSTD (48271) Lehmer generator.
// ----------------------------------------------------------------------------
// One request at a time. A request that fails the range check (max below
// min, or a range size of zero or above 2^31) answers with value 0 and
// range_error set and leaves the generator alone. A served request runs
// the bucket-size division, then a generator step (bit-serial multiply by
// 48271, then fold and bound test), then the bucket-index division, with
// handshakes around them; each rejected draw adds one more generator step.
// Both divisions use the shared bit-serial divider. A new request is taken
// while the last result still waits on the output. Writing seed_wdata with
// seed_we loads the generator state; write it only while the unit is idle.
module lehmer_rng_range_draw_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  lrrd_req_if.sink    req,
  lrrd_res_if.source  res
);
  import lrrd_pkg::*;

  lrrd_state_t state;
  lrrd_state_t state_next;

  logic [31:0] gen_state;
  logic [31:0] min_reg;
  logic [31:0] max_reg;
  logic [31:0] per_bucket;
  logic [31:0] limit;
  logic [31:0] acc_lo;
  logic [31:0] acc_hi;
  logic [3:0]  mul_cnt;

  logic [31:0] draw_value;
  logic        draw_err;

  logic        out_valid;
  logic [31:0] out_value;
  logic        out_err;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic [31:0] div_quo;
  logic [31:0] div_rem;
  div_status_t div_stat;

  logic [31:0] span;
  logic        bad_range;
  logic        mul_bit;
  logic [31:0] fold_x;
  logic [31:0] fold_r;
  logic        out_free;
  logic        accept;

  // range check on the latched request
  assign span      = max_reg - min_reg + 32'd1;
  assign bad_range = (max_reg < min_reg) || (span == '0) || (span > SPAN_TOP);

  // multiplier constant bit, msb first
  assign mul_bit = LEHMER_MULT[mul_cnt];

  // end-around fold of the split products
  assign fold_x = acc_lo + {1'b0, acc_hi[15:0], 15'd0} + {16'd0, acc_hi[31:16]};
  assign fold_r = {1'b0, acc_lo[30:0]} + {31'd0, acc_lo[31]};

  assign out_free = !out_valid || res.ready;
  assign accept   = req.valid && req.ready;

  // shared serial divider
  lrrd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .status    (div_stat)
  );

  assign div_dividend = (state == S_CHECK) ? SPAN_TOP : gen_state;
  assign div_divisor  = (state == S_CHECK) ? span : per_bucket;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (bad_range) begin
          state_next = S_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_stat.done) state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_cnt == 4'd0) state_next = S_FOLD;
      end
      S_FOLD: state_next = S_NEXT;
      S_NEXT: state_next = S_TEST;
      S_TEST: begin
        if (gen_state < limit) begin
          div_start  = 1'b1;
          state_next = S_DIV2;
        end else if (gen_state == MOD_MASK) begin
          state_next = S_OUT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DIV2: begin
        if (div_stat.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
    end else if (seed_we) begin
      gen_state <= seed_wdata;
    end else if (state == S_NEXT) begin
      gen_state <= fold_r;
    end
  end

  // request capture, bucket setup, bit-serial multiply and fold
  always_ff @(posedge clk) begin
    if (accept) begin
      min_reg <= req.min_value;
      max_reg <= req.max_value;
    end
    if (state == S_DIV1 && div_stat.done) begin
      per_bucket <= div_quo;
      limit      <= SPAN_TOP - div_rem;
    end
    if ((state == S_DIV1 && div_stat.done) || (state == S_TEST)) begin
      mul_cnt <= 4'd15;
      acc_lo  <= '0;
      acc_hi  <= '0;
    end else if (state == S_MUL) begin
      mul_cnt <= mul_cnt - 4'd1;
      acc_lo  <= {acc_lo[30:0], 1'b0} + (mul_bit ? {17'd0, gen_state[14:0]} : 32'd0);
      acc_hi  <= {acc_hi[30:0], 1'b0} + (mul_bit ? {15'd0, gen_state[31:15]} : 32'd0);
    end else if (state == S_FOLD) begin
      acc_lo <= fold_x;
    end
  end

  // draw in progress, set by error or by the bucket-index division
  always_ff @(posedge clk) begin
    if (state == S_CHECK || state == S_TEST) begin
      draw_value <= '0;
      draw_err   <= 1'b1;
    end else if (state == S_DIV2 && div_stat.done) begin
      draw_value <= min_reg + div_quo;
      draw_err   <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_value <= draw_value;
      out_err   <= draw_err;
    end
  end

  assign res.valid       = out_valid;
  assign res.value       = out_value;
  assign res.range_error = out_err;

  // checks
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE)
    else $error("ready raised outside idle");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CHECK)
    else $error("accepted request did not enter range check");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while unit idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.range_error |-> res.value == '0)
    else $error("error result with nonzero value");

endmodule
